>>> rtl/vcfs_pkg.sv
// ----------------------------------------------------------------------------
// vcfs_pkg
// Types, constants and helpers shared by the call-frame stack unit.
// ----------------------------------------------------------------------------
package vcfs_pkg;

  localparam int unsigned STACK_DEPTH = 4096;
  localparam int unsigned MAX_REGS    = 255;
  localparam int unsigned MEM_AW      = $clog2(STACK_DEPTH);

  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned LIM_W   = 13;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned REC_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned MAXR_W  = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_STACK_ORIGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIMIT  = 1'b1;

  localparam logic [1:0] OPC_FRAME_BEGIN    = 2'd0;
  localparam logic [1:0] OPC_FRAME_END      = 2'd1;
  localparam logic [1:0] OPC_PUSH           = 2'd2;
  localparam logic [1:0] OPC_FUNCTION_BEGIN = 2'd3;

  typedef enum logic [1:0] {
    OP_FRAME_BEGIN,
    OP_FRAME_END,
    OP_PUSH,
    OP_FUNCTION_BEGIN
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  reg_count;
    logic [63:0] value;
    logic [31:0] pc_in;
    logic [31:0] return_ref;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] pc_out;
    logic        frame_valid;
    logic [11:0] frame_base_addr;
    logic [31:0] return_ref_out;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic        rc_ok;
    logic [7:0]  reg_count;
    logic [63:0] value;
    logic [31:0] pc;
    logic [31:0] rref;
  } cmd_t;

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [LIM_W-1:0] a);
    mem_idx = MEM_AW'(a);
  endfunction

endpackage

>>> rtl/vcfs_ram.sv
// ----------------------------------------------------------------------------
// vcfs_ram
// Single-port RAM, one write or one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module vcfs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/vcfs_front.sv
// ----------------------------------------------------------------------------
// vcfs_front
// Accepts input beats, decodes the opcode and checks the register count,
// and holds decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vcfs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vcfs_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output vcfs_pkg::cmd_t     cmd_o
);
  import vcfs_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  cmd_t                entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                push, pop;
  cmd_t                dec;

  always_comb begin
    dec.reg_count = in_data_i.reg_count;
    dec.value     = in_data_i.value;
    dec.pc        = in_data_i.pc_in;
    dec.rref      = in_data_i.return_ref;
    dec.rc_ok     = MAXR_W'(in_data_i.reg_count) <= MAXR_W'(MAX_REGS);
    case (in_data_i.opcode)
      OPC_FRAME_BEGIN: dec.op = OP_FRAME_BEGIN;
      OPC_FRAME_END:   dec.op = OP_FRAME_END;
      OPC_PUSH:        dec.op = OP_PUSH;
      default:         dec.op = OP_FUNCTION_BEGIN;
    endcase
  end

  assign in_ready_o  = cnt_q != QCNT_W'(QDEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = entry_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= dec;
    end
  end

endmodule

>>> rtl/vcfs_back.sv
// ----------------------------------------------------------------------------
// vcfs_back
// Executes decoded commands against the stack memory, keeps frame base,
// top and open flag, the configuration registers and the result register.
// ----------------------------------------------------------------------------
module vcfs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vcfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vcfs_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  vcfs_pkg::cmd_t                     cmd_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vcfs_pkg::out_item_t                out_data_o
);
  import vcfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ZERO,
    S_FE1,
    S_FE2,
    S_FN1,
    S_TAIL,
    S_RRD,
    S_OUT
  } state_e;

  state_e             state_q;
  cmd_t               cmd_q;
  logic [ADDR_W-1:0]  base_q, top_q, origin_q, sb_q;
  logic [LIM_W-1:0]   limit_q, ptr_q;
  logic [8:0]         left_q;
  logic               open_q;
  logic               res_status_q;
  logic [31:0]        res_pc_q, rref_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [ADDR_W-1:0]  rec;
  logic               rec_ok;
  logic [LIM_W-1:0]   start, rec1, rec2;
  logic               fb_ok, push_ok, fn_top_ok;
  logic               mem_we;
  logic [LIM_W-1:0]   mem_addr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;

  assign rec       = base_q - ADDR_W'(REC_W);
  assign rec_ok    = (base_q >= ADDR_W'(REC_W)) && (rec >= origin_q);
  assign rec1      = {1'b0, rec} + LIM_W'(1);
  assign rec2      = {1'b0, rec} + LIM_W'(2);
  assign start     = open_q ? {1'b0, top_q} : {1'b0, origin_q};
  assign fb_ok     = cmd_q.rc_ok &&
                     ((start + LIM_W'(REC_W) + LIM_W'(cmd_q.reg_count)) < limit_q);
  assign push_ok   = open_q && (({1'b0, top_q} + LIM_W'(1)) < limit_q);
  assign fn_top_ok = ({1'b0, base_q} + LIM_W'(cmd_q.reg_count)) < limit_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state_q)
      S_EXEC: begin
        case (cmd_q.op)
          OP_FRAME_BEGIN: begin
            mem_we    = fb_ok;
            mem_addr  = start;
            mem_wdata = open_q ? WORD_W'({1'b1, base_q}) : '0;
          end
          OP_FRAME_END: begin
            mem_addr = {1'b0, rec};
          end
          OP_PUSH: begin
            mem_we    = push_ok;
            mem_addr  = {1'b0, top_q};
            mem_wdata = cmd_q.value;
          end
          default: begin
            mem_we    = open_q && cmd_q.rc_ok && rec_ok;
            mem_addr  = rec1;
            mem_wdata = WORD_W'(cmd_q.pc);
          end
        endcase
      end
      S_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = ptr_q;
      end
      S_FE1: begin
        mem_addr = rec1;
      end
      S_FN1: begin
        mem_we    = 1'b1;
        mem_addr  = rec2;
        mem_wdata = WORD_W'(cmd_q.rref);
      end
      S_TAIL: begin
        mem_addr = rec2;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  vcfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_idx(mem_addr)),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign cmd_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      base_q       <= '0;
      top_q        <= '0;
      open_q       <= 1'b0;
      origin_q     <= '0;
      limit_q      <= LIM_W'(4096);
      sb_q         <= '0;
      ptr_q        <= '0;
      left_q       <= '0;
      res_status_q <= 1'b1;
      res_pc_q     <= '0;
      rref_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STACK_ORIGIN: origin_q <= cfg_data_i[ADDR_W-1:0];
          CFG_STACK_LIMIT:  limit_q  <= cfg_data_i[LIM_W-1:0];
          default:          limit_q  <= limit_q;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_pc_q <= '0;
          case (cmd_q.op)
            OP_FRAME_BEGIN: begin
              if (fb_ok) begin
                base_q       <= ADDR_W'(start + LIM_W'(REC_W));
                top_q        <= ADDR_W'(start + LIM_W'(REC_W));
                open_q       <= 1'b1;
                ptr_q        <= start + LIM_W'(1);
                left_q       <= 9'd2 + 9'(cmd_q.reg_count);
                res_status_q <= 1'b0;
                state_q      <= S_ZERO;
              end else begin
                res_status_q <= 1'b1;
                state_q      <= S_TAIL;
              end
            end
            OP_FRAME_END: begin
              if (open_q && rec_ok) begin
                res_status_q <= 1'b1;
                state_q      <= S_FE1;
              end else begin
                res_status_q <= !open_q;
                state_q      <= S_TAIL;
                if (open_q) begin
                  open_q <= 1'b0;
                  base_q <= '0;
                  top_q  <= '0;
                end
              end
            end
            OP_PUSH: begin
              res_status_q <= !push_ok;
              state_q      <= S_TAIL;
              if (push_ok) begin
                top_q <= top_q + ADDR_W'(1);
              end
            end
            default: begin
              res_status_q <= !(open_q && cmd_q.rc_ok && fn_top_ok);
              if (open_q && cmd_q.rc_ok && fn_top_ok) begin
                top_q <= ADDR_W'({1'b0, base_q} + LIM_W'(cmd_q.reg_count));
              end
              if (open_q && cmd_q.rc_ok && rec_ok) begin
                state_q <= S_FN1;
              end else begin
                state_q <= S_TAIL;
              end
            end
          endcase
        end
        S_ZERO: begin
          ptr_q  <= ptr_q + LIM_W'(1);
          left_q <= left_q - 9'd1;
          if (left_q == 9'd1) begin
            state_q <= S_TAIL;
          end
        end
        S_FE1: begin
          if (!mem_rdata[ADDR_W]) begin
            open_q       <= 1'b0;
            base_q       <= '0;
            top_q        <= '0;
            res_status_q <= 1'b0;
            state_q      <= S_TAIL;
          end else if (mem_rdata[ADDR_W-1:0] >= origin_q) begin
            sb_q    <= mem_rdata[ADDR_W-1:0];
            state_q <= S_FE2;
          end else begin
            state_q <= S_TAIL;
          end
        end
        S_FE2: begin
          res_pc_q     <= mem_rdata[31:0];
          base_q       <= sb_q;
          top_q        <= rec;
          res_status_q <= 1'b0;
          state_q      <= S_TAIL;
        end
        S_FN1: begin
          state_q <= S_TAIL;
        end
        S_TAIL: begin
          if (open_q && rec_ok) begin
            state_q <= S_RRD;
          end else begin
            rref_q  <= '0;
            state_q <= S_OUT;
          end
        end
        S_RRD: begin
          rref_q  <= mem_rdata[31:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status          <= res_status_q;
            out_q.pc_out          <= res_pc_q;
            out_q.frame_valid     <= open_q;
            out_q.frame_base_addr <= open_q ? base_q : '0;
            out_q.return_ref_out  <= rref_q;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/vm_call_frame_stack_unit.sv
// ----------------------------------------------------------------------------
// vm_call_frame_stack_unit
// Call-frame stack for a virtual machine: frame records and registers kept
// in a word-addressed stack memory, one result beat per command beat.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    vcfs_pkg::in_item_t
//   out      output     out_valid/out_ready  vcfs_pkg::out_item_t
//   cfg      input      cfg_we               cfg_idx, cfg_data
//
// the back end runs one command at a time over the single memory port,
// one word per cycle; frame_begin writes its record and clears its
// registers word by word.
// a two-entry command queue lets input beats arrive while a command runs.
// the result register frees the back end as soon as a stalled beat is taken.
// reset empties the stack; memory contents are not cleared.
// ----------------------------------------------------------------------------
module vm_call_frame_stack_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vcfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vcfs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  vcfs_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output vcfs_pkg::out_item_t            out_data_o
);
  import vcfs_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  vcfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  vcfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/vcfs_checker.sv
// ----------------------------------------------------------------------------
// vcfs_checker
// Port-level checks of the call-frame stack unit, bound to the top level.
// ----------------------------------------------------------------------------
module vcfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vcfs_pkg::out_item_t out_data_o
);
  import vcfs_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // no open frame means no base and no return reference
  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_valid |->
      out_data_o.frame_base_addr == '0 && out_data_o.return_ref_out == '0)
    else $error("closed stack reports frame data");

  // a restored pc comes only from a completed return to an open frame
  a_pc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pc_out != '0 |->
      !out_data_o.status && out_data_o.frame_valid)
    else $error("pc reported without a completed return");

  // an open frame's registers lie above its record
  a_base_above_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_valid |->
      out_data_o.frame_base_addr >= ADDR_W'(REC_W))
    else $error("open frame base below record size");

endmodule

bind vm_call_frame_stack_unit vcfs_checker u_vcfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vm_call_frame_stack_unit. A directed sequence covers
// the refusal cases, the first frame end, record words below the origin and a
// bad saved base. Random phases follow, each under its own origin and limit.
// Every command beat is run through a local model of the frame stack, and each
// result beat is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
  import vcfs_pkg::*;

  localparam logic [63:0] LINK_MARK = 64'h1000;

  class frame_scoreboard;
    logic [63:0]  words [STACK_DEPTH];
    logic [11:0]  cur_base;
    logic [11:0]  frame_top;
    logic         frame_open;
    logic [11:0]  origin;
    logic [12:0]  limit;
    out_item_t    frame_reports[$];
    int           bad_fields;

    function new();
      cur_base   = '0;
      frame_top  = '0;
      frame_open = 1'b0;
      origin     = '0;
      limit      = 13'd4096;
      bad_fields = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_STACK_ORIGIN) origin = data[11:0];
      else limit = data;
    endfunction

    function bit record_at(output int unsigned rec);
      rec = 0;
      if (cur_base < REC_W || cur_base - REC_W < origin) return 1'b0;
      rec = cur_base - REC_W;
      return 1'b1;
    endfunction

    function void drop_stack();
      frame_open = 1'b0;
      cur_base   = '0;
      frame_top  = '0;
    endfunction

    function out_item_t advance_stack(in_item_t it);
      int unsigned start;
      int unsigned rec;
      int unsigned rc;
      logic [63:0] w0;
      logic        ok;
      out_item_t   r;
      ok = 1'b0;
      r  = '0;
      rc = it.reg_count;
      case (it.opcode)
        OPC_FRAME_BEGIN: begin
          start = frame_open ? frame_top : origin;
          if (rc <= MAX_REGS && start + REC_W + rc < limit) begin
            words[start % STACK_DEPTH] = frame_open ? (64'(cur_base) | LINK_MARK) : '0;
            words[(start + 1) % STACK_DEPTH] = '0;
            words[(start + 2) % STACK_DEPTH] = '0;
            for (int i = 0; i < rc; i++) words[(start + REC_W + i) % STACK_DEPTH] = '0;
            cur_base   = 12'(start + REC_W);
            frame_top  = 12'(start + REC_W);
            frame_open = 1'b1;
            ok = 1'b1;
          end
        end
        OPC_FRAME_END: begin
          if (frame_open) begin
            if (!record_at(rec)) begin
              drop_stack();
              ok = 1'b1;
            end else begin
              w0 = words[rec % STACK_DEPTH];
              if ((w0 & LINK_MARK) == '0) begin
                drop_stack();
                ok = 1'b1;
              end else if (w0[11:0] >= origin) begin
                r.pc_out   = words[(rec + 1) % STACK_DEPTH][31:0];
                cur_base   = w0[11:0];
                frame_top  = 12'(rec);
                ok = 1'b1;
              end
            end
          end
        end
        OPC_PUSH: begin
          if (frame_open && frame_top + 1 < limit) begin
            words[frame_top] = it.value;
            frame_top = frame_top + 12'd1;
            ok = 1'b1;
          end
        end
        OPC_FUNCTION_BEGIN: begin
          if (frame_open && rc <= MAX_REGS) begin
            if (record_at(rec)) begin
              words[(rec + 1) % STACK_DEPTH] = 64'(it.pc_in);
              words[(rec + 2) % STACK_DEPTH] = 64'(it.return_ref);
            end
            if (cur_base + rc < limit) begin
              frame_top = 12'(cur_base + rc);
              ok = 1'b1;
            end
          end
        end
      endcase
      r.status          = !ok;
      r.frame_valid     = frame_open;
      r.frame_base_addr = frame_open ? cur_base : '0;
      if (frame_open && record_at(rec)) r.return_ref_out = words[(rec + 2) % STACK_DEPTH][31:0];
      return r;
    endfunction

    function void note_input(in_item_t it);
      frame_reports.push_back(advance_stack(it));
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        bad_fields++;
        if (bad_fields <= 10)
          $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (frame_reports.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10) $display("result beat with nothing expected: %0h", got);
        return;
      end
      want = frame_reports.pop_front();
      compare("status", 64'(want.status), 64'(got.status));
      compare("pc_out", 64'(want.pc_out), 64'(got.pc_out));
      compare("frame_valid", 64'(want.frame_valid), 64'(got.frame_valid));
      compare("frame_base_addr", 64'(want.frame_base_addr), 64'(got.frame_base_addr));
      compare("return_ref_out", 64'(want.return_ref_out), 64'(got.return_ref_out));
    endfunction

    function int pending();
      return frame_reports.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  bit                   calm = 1'b0;
  frame_scoreboard      sb;

  vm_call_frame_stack_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // result side stalls in bursts
  initial begin : ready_gen
    out_ready = 1'b0;
    forever begin : burst
      logic        lvl;
      int unsigned n;
      lvl = calm || ($urandom_range(0, 2) != 0);
      n = lvl ? $urandom_range(1, 30) : $urandom_range(1, 18);
      repeat (n) begin
        @(negedge clk);
        out_ready <= lvl || calm;
      end
    end
  end

  task automatic send_op(op_e op, logic [7:0] rc, logic [63:0] v, logic [31:0] pc,
                         logic [31:0] rr);
    in_item_t    it;
    int unsigned gap;
    it.opcode     = op;
    it.reg_count  = rc;
    it.value      = v;
    it.pc_in      = pc;
    it.return_ref = rr;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(data);
    sb.set_config(idx, CFG_W'(data));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    op_e         op;
    int unsigned roll;
    logic [7:0]  rc;
    roll = $urandom_range(0, 99);
    if (!sb.frame_open) op = (roll < 75) ? OP_FRAME_BEGIN : op_e'($urandom_range(0, 3));
    else if (sb.frame_top + 48 > sb.limit) op = (roll < 50) ? OP_FRAME_END : op_e'($urandom_range(0, 3));
    else if (roll < 20) op = OP_FRAME_BEGIN;
    else if (roll < 55) op = OP_PUSH;
    else if (roll < 75) op = OP_FUNCTION_BEGIN;
    else op = OP_FRAME_END;
    roll = $urandom_range(0, 99);
    if (roll < 85) rc = 8'($urandom_range(0, 12));
    else if (roll < 95) rc = 8'($urandom_range(0, 255));
    else rc = 8'd255;
    send_op(op, rc, {$urandom, $urandom}, $urandom, $urandom);
  endtask

  initial begin : main
    int unsigned org;
    int unsigned lim;
    sb       = new();
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    write_cfg(CFG_STACK_ORIGIN, 0);
    write_cfg(CFG_STACK_LIMIT, 4096);
    // nothing open yet
    send_op(OP_FRAME_END, 8'd0, '0, '0, '0);
    send_op(OP_PUSH, 8'd0, '1, '0, '0);
    send_op(OP_FUNCTION_BEGIN, 8'd255, '0, '1, '1);
    send_op(OP_FRAME_BEGIN, 8'd0, '0, '0, '0);
    send_op(OP_FUNCTION_BEGIN, 8'd255, '0, 32'hffff_ffff, 32'hffff_ffff);
    send_op(OP_PUSH, 8'd0, 64'hffff_ffff_ffff_ffff, '0, '0);
    send_op(OP_PUSH, 8'd0, '0, '0, '0);
    send_op(OP_FRAME_BEGIN, 8'd255, '0, '0, '0);
    send_op(OP_FUNCTION_BEGIN, 8'd3, '0, 32'h1234_5678, 32'ha5a5_a5a5);
    send_op(OP_PUSH, 8'd0, {$urandom, $urandom}, '0, '0);
    send_op(OP_FRAME_END, 8'd0, '0, '0, '0);
    // first frame end empties the stack
    send_op(OP_FRAME_END, 8'd0, '0, '0, '0);

    // overflow cases near a tight limit
    settle();
    write_cfg(CFG_STACK_ORIGIN, 4000);
    write_cfg(CFG_STACK_LIMIT, 4010);
    send_op(OP_FRAME_BEGIN, 8'd7, '0, '0, '0);
    send_op(OP_FRAME_BEGIN, 8'd6, '0, '0, '0);
    send_op(OP_FUNCTION_BEGIN, 8'd6, '0, 32'h0000_0001, 32'h8000_0000);
    send_op(OP_PUSH, 8'd0, {$urandom, $urandom}, '0, '0);
    send_op(OP_FUNCTION_BEGIN, 8'd7, '0, 32'hdead_beef, 32'h0bad_f00d);

    // record now lies below the origin
    settle();
    write_cfg(CFG_STACK_ORIGIN, 4095);
    send_op(OP_FUNCTION_BEGIN, 8'd0, '0, 32'h5555_aaaa, 32'h3333_cccc);
    send_op(OP_FRAME_END, 8'd0, '0, '0, '0);

    // saved base below the origin
    settle();
    write_cfg(CFG_STACK_ORIGIN, 0);
    write_cfg(CFG_STACK_LIMIT, 4096);
    send_op(OP_FRAME_BEGIN, 8'd0, '0, '0, '0);
    send_op(OP_PUSH, 8'd0, {$urandom, $urandom}, '0, '0);
    send_op(OP_PUSH, 8'd0, {$urandom, $urandom}, '0, '0);
    send_op(OP_FRAME_BEGIN, 8'd1, '0, '0, '0);
    settle();
    write_cfg(CFG_STACK_ORIGIN, 4);
    send_op(OP_FRAME_END, 8'd0, '0, '0, '0);

    // zero limit refuses everything that grows the stack
    settle();
    write_cfg(CFG_STACK_ORIGIN, 0);
    write_cfg(CFG_STACK_LIMIT, 0);
    send_op(OP_FRAME_BEGIN, 8'd0, '0, '0, '0);
    send_op(OP_PUSH, 8'd0, {$urandom, $urandom}, '0, '0);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin org = 0; lim = 4096; end
        1: begin org = 0; lim = 160; end
        2: begin org = 1000; lim = 1300; end
        3: begin org = 4050; lim = 4096; end
        4: begin
          org = $urandom_range(0, 3000);
          lim = org + $urandom_range(8, 1000);
        end
        default: begin org = 0; lim = 4096; end
      endcase
      calm = (p == 5);
      write_cfg(CFG_STACK_ORIGIN, org);
      write_cfg(CFG_STACK_LIMIT, lim);
      repeat (72) random_item();
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.bad_fields == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
rtl/vcfs_pkg.sv
rtl/vcfs_ram.sv
rtl/vcfs_front.sv
rtl/vcfs_back.sv
rtl/vm_call_frame_stack_unit.sv
rtl/vcfs_checker.sv
tb/sv/testbench.sv
